// ===== src/psc_pkg.sv =====
package psc_pkg;

  localparam int SMP_W     = 12;
  localparam int DIFF_W    = 13;
  localparam int TS_W      = 30;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int OFS_W     = 12;
  localparam int DAC_W     = 12;
  localparam int MAG_W     = 13;
  localparam int GAIN_W    = 12;
  localparam int SCALED_W  = 25;
  localparam int FRAC_SH   = 8;
  localparam int TRUNC_SH  = 20;
  localparam int Q_LO_W    = 17;

  localparam int DIV_NUM_W = SCALED_W + FRAC_SH;
  localparam int DIV_DEN_W = TS_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic [GAIN_W-1:0] DERIV_GAIN = 12'd3000;
  localparam logic [DAC_W-1:0]  DAC_MAX    = 12'd4095;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_IN_PHASE   = 2'd0,
    REG_COEF_QUADRATURE = 2'd1,
    REG_DAC_OFFSET      = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] smp;
    logic [TS_W-1:0]          ts;
  } ring_entry_t;

  typedef struct packed {
    logic accept;
    logic prep;
    logic gstart;
    logic gmul;
    logic gap_load;
    logic dstart;
    logic q_clear;
    logic q_load;
    logic mul_a;
    logic mul_b;
    logic mul_c;
    logic mul_d;
    logic scale;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic gap_zero;
    logic out_free;
  } stat_t;

endpackage

// ===== src/psc_div.sv =====
module psc_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [psc_pkg::DIV_NUM_W-1:0]   num,
  input  logic [psc_pkg::DIV_DEN_W-1:0]   den,
  output logic                            done,
  output logic [psc_pkg::DIV_NUM_W-1:0]   quot
);

  localparam logic [psc_pkg::DIV_CNT_W-1:0] LAST_STEP =
    psc_pkg::DIV_CNT_W'(psc_pkg::DIV_NUM_W - 1);

  logic                             busy;
  logic [psc_pkg::DIV_CNT_W-1:0]    cnt;
  logic [psc_pkg::DIV_NUM_W-1:0]    num_sh;
  logic [psc_pkg::DIV_DEN_W-1:0]    den_r;
  logic [psc_pkg::DIV_DEN_W-1:0]    rem;
  logic [psc_pkg::DIV_DEN_W:0]      trial;
  logic [psc_pkg::DIV_DEN_W:0]      trial_sub;
  logic                             ge;

  // one restoring step per cycle
  assign trial     = {rem, num_sh[psc_pkg::DIV_NUM_W-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign ge        = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      den_r  <= den;
      rem    <= '0;
      quot   <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[psc_pkg::DIV_NUM_W-2:0], 1'b0};
      rem    <= ge ? trial_sub[psc_pkg::DIV_DEN_W-1:0] : trial[psc_pkg::DIV_DEN_W-1:0];
      quot   <= {quot[psc_pkg::DIV_NUM_W-2:0], ge};
    end
  end

endmodule

// ===== src/psc_dp.sv =====
module psc_dp #(
  parameter int RING_DEPTH = 4,
  parameter int DERIV_SPAN = 2,
  parameter int TIME_WRAP  = 1000000000
) (
  input  logic                              clk,
  input  logic                              rst,
  input  psc_pkg::cmd_t                     cmd,
  output psc_pkg::stat_t                    stat,
  input  logic [psc_pkg::SMP_W-1:0]         sample_pos,
  input  logic [psc_pkg::SMP_W-1:0]         sample_neg,
  input  logic [psc_pkg::TS_W-1:0]          timestamp_us,
  input  logic                              cfg_we,
  input  logic [psc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psc_pkg::CFG_W-1:0]         cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [psc_pkg::DAC_W-1:0]         dac_code,
  output logic                              clipped
);

  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int OLD_OFS    = DERIV_SPAN % RING_DEPTH;
  localparam bit OLD_IS_NEW = (OLD_OFS == 0);
  localparam int P_W        = 42;
  localparam int OPB_W      = 18;
  localparam int ACC_W      = 60;
  localparam int TR_W       = ACC_W - psc_pkg::TRUNC_SH;
  localparam int VAL_W      = TR_W + 1;
  localparam int Q_HI_W     = psc_pkg::DIV_NUM_W - psc_pkg::Q_LO_W;

  localparam logic [psc_pkg::TS_W-1:0] WRAP      = psc_pkg::TS_W'(TIME_WRAP);
  localparam logic [psc_pkg::TS_W-1:0] RECIP     =
    psc_pkg::TS_W'((64'd1 << psc_pkg::TS_W) / TIME_WRAP);
  localparam logic [SLOT_W:0]          DEPTH_EXT = (SLOT_W+1)'(RING_DEPTH);
  localparam logic [SLOT_W:0]          OLD_BACK  = (SLOT_W+1)'(RING_DEPTH - OLD_OFS);
  localparam logic [SLOT_W:0]          MID_BACK  = (SLOT_W+1)'(RING_DEPTH - 1);
  localparam logic [SLOT_W-1:0]        LAST_SLOT = SLOT_W'(RING_DEPTH - 1);
  localparam logic [ACC_W-1:0]         TRUNC_BIAS =
    ACC_W'((1 << psc_pkg::TRUNC_SH) - 1);

  function automatic logic [SLOT_W-1:0] ring_back(input logic [SLOT_W-1:0] s,
                                                   input logic [SLOT_W:0]   b);
    logic [SLOT_W:0] sum;
    sum = {1'b0, s} + b;
    if (sum >= DEPTH_EXT) sum = sum - DEPTH_EXT;
    return sum[SLOT_W-1:0];
  endfunction

  // configuration
  logic signed [psc_pkg::CFG_W-1:0] coef_i;
  logic signed [psc_pkg::CFG_W-1:0] coef_q;
  logic [psc_pkg::OFS_W-1:0]        dac_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_i     <= '0;
      coef_q     <= '0;
      dac_offset <= '0;
    end else if (cfg_we) begin
      unique case (psc_pkg::reg_index_t'(cfg_index))
        psc_pkg::REG_COEF_IN_PHASE:   coef_i     <= cfg_data;
        psc_pkg::REG_COEF_QUADRATURE: coef_q     <= cfg_data;
        psc_pkg::REG_DAC_OFFSET:      dac_offset <= cfg_data[psc_pkg::OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // sample ring
  psc_pkg::ring_entry_t             ring [RING_DEPTH];
  logic [RING_DEPTH-1:0]            vld;
  logic [SLOT_W-1:0]                slot;
  logic [SLOT_W-1:0]                old_addr;
  logic [SLOT_W-1:0]                mid_addr;
  logic signed [psc_pkg::DIFF_W-1:0] new_diff;
  psc_pkg::ring_entry_t             new_e;
  psc_pkg::ring_entry_t             old_e;
  logic signed [psc_pkg::DIFF_W-1:0] mid_smp;

  assign old_addr = ring_back(slot, OLD_BACK);
  assign mid_addr = ring_back(slot, MID_BACK);
  assign new_diff = $signed({1'b0, sample_pos}) - $signed({1'b0, sample_neg});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      slot <= '0;
    end else if (cmd.accept) begin
      vld[slot] <= 1'b1;
      slot      <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring[slot] <= '{smp: new_diff, ts: timestamp_us};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      new_e   <= '{smp: new_diff, ts: timestamp_us};
      old_e   <= vld[old_addr] ? ring[old_addr] : '0;
      mid_smp <= vld[mid_addr] ? ring[mid_addr].smp : '0;
    end
  end

  // differences
  psc_pkg::ring_entry_t            old_sel;
  logic [psc_pkg::DIFF_W:0]        diff_w;
  logic [psc_pkg::TS_W:0]          dt_w;
  logic [psc_pkg::DIFF_W:0]        diff_abs;
  logic [psc_pkg::TS_W:0]          dt_abs;
  logic                            diff_neg;
  logic [psc_pkg::MAG_W-1:0]       diff_mag;
  logic                            dt_neg;
  logic [psc_pkg::TS_W-1:0]        dt_mag;

  assign old_sel  = OLD_IS_NEW ? new_e : old_e;
  assign diff_w   = {new_e.smp[psc_pkg::DIFF_W-1], new_e.smp}
                  - {old_sel.smp[psc_pkg::DIFF_W-1], old_sel.smp};
  assign dt_w     = {1'b0, new_e.ts} - {1'b0, old_sel.ts};
  assign diff_abs = diff_w[psc_pkg::DIFF_W] ? -diff_w : diff_w;
  assign dt_abs   = dt_w[psc_pkg::TS_W] ? -dt_w : dt_w;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      diff_neg <= diff_w[psc_pkg::DIFF_W];
      diff_mag <= diff_abs[psc_pkg::MAG_W-1:0];
      dt_neg   <= dt_w[psc_pkg::TS_W];
      dt_mag   <= dt_abs[psc_pkg::TS_W-1:0];
    end
  end

  // time gap: reciprocal multiply, back multiply, one correcting subtract
  logic [2*psc_pkg::TS_W-1:0]       qm_w;
  logic [psc_pkg::TS_W-1:0]         qe;
  logic [psc_pkg::TS_W:0]           qw_w;
  logic [psc_pkg::TS_W:0]           rr;
  logic [psc_pkg::TS_W:0]           rr_fix;
  logic [psc_pkg::TS_W-1:0]         gap_rem;

  assign qm_w    = {{psc_pkg::TS_W{1'b0}}, dt_mag} * {{psc_pkg::TS_W{1'b0}}, RECIP};
  assign qw_w    = {1'b0, qe} * {1'b0, WRAP};
  assign rr_fix  = (rr >= {1'b0, WRAP}) ? rr - {1'b0, WRAP} : rr;
  assign gap_rem = rr_fix[psc_pkg::TS_W-1:0];

  // derivative divider
  logic [psc_pkg::SCALED_W-1:0]     scaled_w;
  logic [psc_pkg::SCALED_W-1:0]     scaled;
  logic [psc_pkg::DIV_NUM_W-1:0]    div_num;
  logic [psc_pkg::DIV_DEN_W-1:0]    div_den;
  logic                             div_done;
  logic [psc_pkg::DIV_NUM_W-1:0]    div_quot;
  logic [psc_pkg::TS_W-1:0]         gap;
  logic [psc_pkg::DIV_NUM_W-1:0]    q;

  assign scaled_w = {{(psc_pkg::SCALED_W - psc_pkg::MAG_W){1'b0}}, diff_mag}
                  * {{(psc_pkg::SCALED_W - psc_pkg::GAIN_W){1'b0}}, psc_pkg::DERIV_GAIN};
  assign div_num  = {scaled, {psc_pkg::FRAC_SH{1'b0}}};
  assign div_den  = gap;

  psc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.dstart),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.gstart) begin
      scaled <= scaled_w;
      qe     <= qm_w[2*psc_pkg::TS_W-1:psc_pkg::TS_W];
    end
    if (cmd.gmul) rr <= {1'b0, dt_mag} - qw_w;
    if (cmd.gap_load) begin
      gap <= (dt_neg && (gap_rem != '0)) ? WRAP - gap_rem : gap_rem;
    end
    if (cmd.q_clear) begin
      q <= '0;
    end else if (cmd.q_load) begin
      q <= div_quot;
    end
  end

  // shared multiplier and accumulator
  logic signed [psc_pkg::CFG_W-1:0] op_a;
  logic signed [OPB_W-1:0]          op_b;
  logic signed [P_W-1:0]            prod;
  logic signed [P_W-1:0]            p;
  logic signed [ACC_W-1:0]          p_ext;
  logic signed [ACC_W-1:0]          acc;

  always_comb begin
    op_a = cmd.mul_c ? coef_i : coef_q;
    priority if (cmd.mul_a) begin
      op_b = {{(OPB_W - psc_pkg::Q_LO_W){1'b0}}, q[psc_pkg::Q_LO_W-1:0]};
    end else if (cmd.mul_b) begin
      op_b = {{(OPB_W - Q_HI_W){1'b0}}, q[psc_pkg::DIV_NUM_W-1:psc_pkg::Q_LO_W]};
    end else if (cmd.mul_c) begin
      op_b = {{(OPB_W - psc_pkg::DIFF_W){mid_smp[psc_pkg::DIFF_W-1]}}, mid_smp};
    end else begin
      op_b = '0;
    end
  end

  assign prod  = op_a * op_b;
  assign p_ext = {{(ACC_W - P_W){p[P_W-1]}}, p};

  always_ff @(posedge clk) begin
    if (cmd.mul_a | cmd.mul_b | cmd.mul_c) p <= prod;
    if (cmd.mul_b) begin
      acc <= p_ext;
    end else if (cmd.mul_c) begin
      acc <= acc + (p_ext <<< psc_pkg::Q_LO_W);
    end else if (cmd.mul_d) begin
      acc <= diff_neg ? (p_ext <<< psc_pkg::FRAC_SH) - acc
                      : (p_ext <<< psc_pkg::FRAC_SH) + acc;
    end
  end

  // truncate toward zero, add offset, saturate
  logic [ACC_W-1:0]  acc_rnd;
  logic [VAL_W-1:0]  val_w;
  logic [VAL_W-1:0]  val;
  logic              val_neg;
  logic              val_high;

  assign acc_rnd  = acc + (acc[ACC_W-1] ? TRUNC_BIAS : '0);
  assign val_w    = {acc_rnd[ACC_W-1], acc_rnd[ACC_W-1:psc_pkg::TRUNC_SH]}
                  + {{(VAL_W - psc_pkg::OFS_W){1'b0}}, dac_offset};
  assign val_neg  = val[VAL_W-1];
  assign val_high = !val_neg && (val > {{(VAL_W - psc_pkg::DAC_W){1'b0}}, psc_pkg::DAC_MAX});

  always_ff @(posedge clk) begin
    if (cmd.scale) val <= val_w;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      priority if (val_neg) begin
        dac_code <= '0;
        clipped  <= 1'b1;
      end else if (val_high) begin
        dac_code <= psc_pkg::DAC_MAX;
        clipped  <= 1'b1;
      end else begin
        dac_code <= val[psc_pkg::DAC_W-1:0];
        clipped  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.div_done = div_done;
  assign stat.gap_zero = (gap == '0);
  assign stat.out_free = !out_valid || out_ready;

  a_clip_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> (dac_code == '0 || dac_code == psc_pkg::DAC_MAX))
    else $error("clipped result with a code inside the range");

  a_gap_range: assert property (@(posedge clk) disable iff (rst)
    cmd.gap_load |=> gap < WRAP)
    else $error("time gap not reduced below the wrap");

  a_q_on_done: assert property (@(posedge clk) disable iff (rst)
    cmd.q_load |-> div_done)
    else $error("quotient taken before the divider finished");

endmodule

// ===== src/psc_ctrl.sv =====
module psc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  psc_pkg::stat_t  stat,
  output psc_pkg::cmd_t   cmd
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_PREP   = 13'b0000000000010,
    S_GSTART = 13'b0000000000100,
    S_GDIV   = 13'b0000000001000,
    S_GFIX   = 13'b0000000010000,
    S_GCHK   = 13'b0000000100000,
    S_DDIV   = 13'b0000001000000,
    S_MULA   = 13'b0000010000000,
    S_MULB   = 13'b0000100000000,
    S_MULC   = 13'b0001000000000,
    S_MULD   = 13'b0010000000000,
    S_SCALE  = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_GSTART;
      end
      S_GSTART: begin
        cmd.gstart = 1'b1;
        state_next = S_GDIV;
      end
      S_GDIV: begin
        cmd.gmul   = 1'b1;
        state_next = S_GFIX;
      end
      S_GFIX: begin
        cmd.gap_load = 1'b1;
        state_next   = S_GCHK;
      end
      S_GCHK: begin
        if (stat.gap_zero) begin
          cmd.q_clear = 1'b1;
          state_next  = S_MULA;
        end else begin
          cmd.dstart = 1'b1;
          state_next = S_DDIV;
        end
      end
      S_DDIV: begin
        if (stat.div_done) begin
          cmd.q_load = 1'b1;
          state_next = S_MULA;
        end
      end
      S_MULA: begin
        cmd.mul_a  = 1'b1;
        state_next = S_MULB;
      end
      S_MULB: begin
        cmd.mul_b  = 1'b1;
        state_next = S_MULC;
      end
      S_MULC: begin
        cmd.mul_c  = 1'b1;
        state_next = S_MULD;
      end
      S_MULD: begin
        cmd.mul_d  = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_done_waiting: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == S_DDIV))
    else $error("divider finished outside a wait state");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result register overwritten while still held");

  a_no_zero_div: assert property (@(posedge clk) disable iff (rst)
    cmd.dstart |-> !stat.gap_zero)
    else $error("derivative division started on a zero gap");

endmodule

// ===== src/phase_shifted_current_synth.sv =====
// phase-shifted current synthesiser
// input channel: in_valid/in_ready, one transfer carries sample_pos, sample_neg
//   and timestamp_us; the difference is stored in a ring with its timestamp
// output channel: out_valid/out_ready, one transfer per input with dac_code
//   and clipped
// configuration: cfg_we writes cfg_data to register cfg_index (0 in-phase
//   coefficient, 1 quadrature coefficient, 2 dac offset), others ignored;
//   user must write only while the block is idle, which it does not enforce
// in_ready returns in the cycle after the result is loaded, and no new
//   input is taken before then; the derivative quotient comes from one
//   bit-per-cycle divider of 33 steps, skipped when the time gap to the
//   older sample is zero; the gap modulo the time wrap is reduced in the
//   states S_GSTART, S_GDIV and S_GFIX
// reset: ring emptied, write slot, coefficients, offset cleared, no result held
// stall: a finished result waits in the output register; the next item may
//   be taken meanwhile and its result is held back until that register frees
module phase_shifted_current_synth #(
  parameter int RING_DEPTH = 4,
  parameter int DERIV_SPAN = 2,
  parameter int TIME_WRAP  = 1000000000
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [psc_pkg::SMP_W-1:0]       sample_pos,
  input  logic [psc_pkg::SMP_W-1:0]       sample_neg,
  input  logic [psc_pkg::TS_W-1:0]        timestamp_us,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [psc_pkg::DAC_W-1:0]       dac_code,
  output logic                            clipped,
  input  logic                            cfg_we,
  input  logic [psc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psc_pkg::CFG_W-1:0]       cfg_data
);

  psc_pkg::cmd_t  cmd;
  psc_pkg::stat_t stat;

  psc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  psc_dp #(
    .RING_DEPTH (RING_DEPTH),
    .DERIV_SPAN (DERIV_SPAN),
    .TIME_WRAP  (TIME_WRAP)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample_pos   (sample_pos),
    .sample_neg   (sample_neg),
    .timestamp_us (timestamp_us),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .dac_code     (dac_code),
    .clipped      (clipped)
  );

endmodule
